@@ sv/fefe_pkg.sv @@
// fire effect frame engine: shared constants, types and the heat palette
// used by the heat store, the burn datapath and the top level
package fefe_pkg;

    localparam int COLS           = 8;
    localparam int CELL_W         = 4;
    localparam int ROW_W          = COLS * CELL_W;
    localparam int NOISE_CNT      = 6;
    localparam int NOISE_W        = NOISE_CNT * CELL_W;
    localparam int ROW_IDX_W      = 4;
    localparam int OUT_DATA_W     = 40;
    localparam int SHOWN_ROWS_DEF = 15;

    // palette codes
    localparam logic [CELL_W-1:0] PAL_BLACK     = 4'd0;
    localparam logic [CELL_W-1:0] PAL_WHITE     = 4'd1;
    localparam logic [CELL_W-1:0] PAL_RED       = 4'd2;
    localparam logic [CELL_W-1:0] PAL_YELLOW    = 4'd7;
    localparam logic [CELL_W-1:0] PAL_LIGHT_RED = 4'd10;

    // heat levels where the palette changes
    localparam logic [CELL_W-1:0] HEAT_RED       = 4'd3;
    localparam logic [CELL_W-1:0] HEAT_LIGHT_RED = 4'd4;
    localparam logic [CELL_W-1:0] HEAT_YELLOW    = 4'd5;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    function automatic logic [CELL_W-1:0] heat_to_color(input logic [CELL_W-1:0] heat);
        logic [CELL_W-1:0] color;
        if (heat < HEAT_RED) begin
            color = PAL_BLACK;
        end else if (heat == HEAT_RED) begin
            color = PAL_RED;
        end else if (heat == HEAT_LIGHT_RED) begin
            color = PAL_LIGHT_RED;
        end else if (heat == HEAT_YELLOW) begin
            color = PAL_YELLOW;
        end else begin
            color = PAL_WHITE;
        end
        return color;
    endfunction

endpackage

@@ sv/fefe_heat_mem.sv @@
// fire effect frame engine: heat store, one row of eight cells per word
// one write and one registered read port, per-row valid bits; uses fefe_pkg
module fefe_heat_mem
    import fefe_pkg::*;
#(
    parameter int DEPTH = SHOWN_ROWS_DEF + 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_ctl         i_ctl,
    input  logic [AW-1:0]    i_waddr,
    input  logic [ROW_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [ROW_W-1:0] o_rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [ROW_W-1:0] r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    // a row never written reads as zero heat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_ctl.we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_ctl.re) begin
                r_rvld <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

@@ sv/fefe_burn.sv @@
// fire effect frame engine: cooling average of one row and its palette colors
// combines the old rows r, r+1 and r+2; uses fefe_pkg
module fefe_burn
    import fefe_pkg::*;
(
    input  logic [ROW_W-1:0] i_row0,
    input  logic [ROW_W-1:0] i_row1,
    input  logic [ROW_W-1:0] i_row2,
    output logic [ROW_W-1:0] o_heat,
    output logic [ROW_W-1:0] o_colors
);

    always_comb begin
        logic [CELL_W-1:0] left;
        logic [CELL_W-1:0] right;
        logic [CELL_W+1:0] sum;
        logic [CELL_W-1:0] heat;
        o_heat   = '0;
        o_colors = '0;
        for (int c = 0; c < COLS; c++) begin
            // left and right neighbors wrap into the adjacent linear cells
            if (c == 0) begin
                left = i_row0[(COLS-1)*CELL_W +: CELL_W];
            end else begin
                left = i_row1[(c-1)*CELL_W +: CELL_W];
            end
            if (c == COLS - 1) begin
                right = i_row2[0 +: CELL_W];
            end else begin
                right = i_row1[(c+1)*CELL_W +: CELL_W];
            end
            sum = (CELL_W+2)'(left) + (CELL_W+2)'(i_row1[c*CELL_W +: CELL_W])
                + (CELL_W+2)'(right) + (CELL_W+2)'(i_row2[c*CELL_W +: CELL_W]);
            heat = sum[CELL_W+1:2];
            o_heat[c*CELL_W +: CELL_W]   = heat;
            o_colors[c*CELL_W +: CELL_W] = heat_to_color(heat);
        end
    end

endmodule

@@ sv/fire_effect_frame_engine_core.sv @@
// fire effect frame engine: top level with row sequencer and output register
// instantiates fefe_heat_mem and fefe_burn; uses fefe_pkg
//
// usage:
//   s_axis carries one frame tick per transfer, six 4-bit noise values for
//   the source row. for each tick the block cools the heat store row by row
//   (each cell from the two rows below and the neighbors in the row below)
//   and then writes the noise into the source row.
//   m_axis carries SHOWN_ROWS transfers per tick, one per displayed row, top
//   row first, with the row number and eight palette colors; tlast marks the
//   final row.
//   each row needs one memory read plus a capture state and a write state on
//   the heat store, with three reads to prime the row window. a new tick is
//   taken only once the previous one is done; the last row may still wait in
//   the output register.
//   when the receiver stalls, the sequencer holds before each row write until
//   the output register is free, so nothing is lost.
//   reset (synchronous, active low) clears the heat store to zero through the
//   per-row valid bits and returns the sequencer to idle at once.
module fire_effect_frame_engine_core
    import fefe_pkg::*;
#(
    parameter int SHOWN_ROWS = SHOWN_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // noise_a, noise_b, noise_c, noise_d, noise_e, noise_f
    input  logic [NOISE_W-1:0]    s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // row_index, color_col0 .. color_col7, zero padding
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int DEPTH = SHOWN_ROWS + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SHOWN_ROWS + 3);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CAP   = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_NOISE = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_row, n_row;
    logic [CW-1:0]         r_rd, n_rd;
    logic [NOISE_W-1:0]    r_noise, n_noise;
    logic [ROW_W-1:0]      r_w0, n_w0;
    logic [ROW_W-1:0]      r_w1, n_w1;
    logic [ROW_W-1:0]      r_w2, n_w2;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  r_out_last, n_out_last;

    t_mem_ctl         mem_ctl;
    logic [AW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [ROW_W-1:0] mem_rdata;
    logic [ROW_W-1:0] new_heat;
    logic [ROW_W-1:0] new_colors;
    logic             out_free;
    logic             row_last;

    fefe_heat_mem #(
        .DEPTH (DEPTH)
    ) u_heat_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (AW'(r_rd)),
        .o_rdata (mem_rdata)
    );

    fefe_burn u_burn (
        .i_row0   (r_w0),
        .i_row1   (r_w1),
        .i_row2   (r_w2),
        .o_heat   (new_heat),
        .o_colors (new_colors)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign row_last = (r_row == CW'(SHOWN_ROWS - 1));

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_rd        = r_rd;
        n_noise     = r_noise;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        mem_ctl     = '0;
        mem_waddr   = AW'(r_row);
        mem_wdata   = new_heat;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_noise = s_axis_tdata;
                    n_row   = '0;
                    n_rd    = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                mem_ctl.re = 1'b1;
                n_state    = S_CAP;
            end
            S_CAP: begin
                // slide the three-row window down by one row
                n_w0 = r_w1;
                n_w1 = r_w2;
                n_w2 = mem_rdata;
                n_rd = r_rd + CW'(1);
                if (r_rd < CW'(r_row + CW'(2))) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (out_free) begin
                    mem_ctl.we  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = {(OUT_DATA_W - ROW_W - ROW_IDX_W)'(0), new_colors,
                                   ROW_IDX_W'(r_row)};
                    n_out_last  = row_last;
                    if (row_last) begin
                        n_state = S_NOISE;
                    end else begin
                        n_row   = r_row + CW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_NOISE: begin
                // edge columns of the source row stay cold
                mem_ctl.we = 1'b1;
                mem_waddr  = AW'(SHOWN_ROWS);
                mem_wdata  = {CELL_W'(0), r_noise, CELL_W'(0)};
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_noise    <= n_noise;
        r_w0       <= n_w0;
        r_w1       <= n_w1;
        r_w2       <= n_w2;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_last_row_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[ROW_IDX_W-1:0] == ROW_IDX_W'(SHOWN_ROWS - 1)))
        else $error("tlast on a row other than the final one");

    a_write_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && !r_out_valid) |=> r_out_valid)
        else $error("row write did not load the output register");

    a_read_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ((CW+1)'(r_rd) <= (CW+1)'(r_row) + (CW+1)'(3)))
        else $error("read pointer ran ahead of the row window");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.we |-> ((CW+1)'(mem_waddr) <= (CW+1)'(SHOWN_ROWS)))
        else $error("heat store write outside the updated rows");

    a_noise_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NOISE) |-> $past(r_state == S_WR && row_last))
        else $error("source row written before the last row was done");
`endif

endmodule

@@ tb/fire_rows_checker.sv @@
// row checker for the fire effect frame engine: watches both stream channels,
// keeps its own heat store and palette, and compares every row transfer
// depends on fefe_pkg for widths and palette codes
module fire_rows_checker
    import fefe_pkg::*;
#(
    parameter int SHOWN_ROWS = SHOWN_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // noise_a, noise_b, noise_c, noise_d, noise_e, noise_f
    input  logic [NOISE_W-1:0]    s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // row_index, color_col0 .. color_col7, zero padding
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    output int                    o_err_cnt,
    output int                    o_rows_due
);

    localparam int BURN_CELLS = COLS * SHOWN_ROWS;
    localparam int HEAT_CELLS = COLS * (SHOWN_ROWS + 2);

    typedef struct packed {
        logic [ROW_IDX_W-1:0]        row_idx;
        logic [COLS-1:0][CELL_W-1:0] color;
        logic                        last;
    } t_fire_row;

    logic [CELL_W-1:0] heat [HEAT_CELLS];
    t_fire_row         rows_due [$];
    int                err_cnt = 0;

    function automatic logic [CELL_W-1:0] shade(input logic [CELL_W-1:0] level);
        logic [CELL_W-1:0] color;
        if (level < HEAT_RED) begin
            color = PAL_BLACK;
        end else begin
            case (level)
                HEAT_RED:       color = PAL_RED;
                HEAT_LIGHT_RED: color = PAL_LIGHT_RED;
                HEAT_YELLOW:    color = PAL_YELLOW;
                default:        color = PAL_WHITE;
            endcase
        end
        return color;
    endfunction

    // cool the shown rows from the old values below, drop in the noise,
    // then queue one expected row per shown row
    task automatic burn_tick(input logic [NOISE_W-1:0] noise);
        logic [CELL_W+1:0] sum;
        t_fire_row         row;
        for (int i = 0; i < BURN_CELLS; i++) begin
            sum = (CELL_W+2)'(heat[i + 7]) + (CELL_W+2)'(heat[i + 8])
                + (CELL_W+2)'(heat[i + 9]) + (CELL_W+2)'(heat[i + 16]);
            heat[i] = sum[CELL_W+1:2];
        end
        for (int k = 0; k < NOISE_CNT; k++) begin
            heat[BURN_CELLS + 1 + k] = noise[CELL_W*k +: CELL_W];
        end
        for (int r = 0; r < SHOWN_ROWS; r++) begin
            row.row_idx = r[ROW_IDX_W-1:0];
            for (int c = 0; c < COLS; c++) begin
                row.color[c] = shade(heat[r*COLS + c]);
            end
            row.last = (r == SHOWN_ROWS - 1);
            rows_due.push_back(row);
        end
    endtask

    task automatic check_row(input logic [OUT_DATA_W-1:0] data, input logic last);
        t_fire_row         want;
        logic [CELL_W-1:0] got;
        if (rows_due.size() == 0) begin
            $error("row transfer with no row expected: tdata %h tlast %b", data, last);
            err_cnt++;
            return;
        end
        want = rows_due.pop_front();
        if (data[ROW_IDX_W-1:0] !== want.row_idx) begin
            $error("row_index expected %0d actual %0d", want.row_idx, data[ROW_IDX_W-1:0]);
            err_cnt++;
        end
        for (int c = 0; c < COLS; c++) begin
            got = data[ROW_IDX_W + CELL_W*c +: CELL_W];
            if (got !== want.color[c]) begin
                $error("color_col%0d (row %0d) expected %0d actual %0d",
                       c, want.row_idx, want.color[c], got);
                err_cnt++;
            end
        end
        if (last !== want.last) begin
            $error("last_row (row %0d) expected %0d actual %0d", want.row_idx, want.last, last);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HEAT_CELLS; i++) begin
                heat[i] = '0;
            end
            rows_due.delete();
        end else begin
            // a row leaving at this edge always belongs to an earlier tick
            if (m_axis_tvalid && m_axis_tready) begin
                check_row(m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                burn_tick(s_axis_tdata);
            end
        end
        o_err_cnt  <= err_cnt;
        o_rows_due <= rows_due.size();
    end

endmodule

@@ tb/fire_effect_frame_engine_core_tb.sv @@
// testbench top for fire_effect_frame_engine_core: clock, reset, tick stimulus
// and random receiver stalls; checking is done by fire_rows_checker
// depends on fefe_pkg, fire_effect_frame_engine_core and fire_rows_checker
module fire_effect_frame_engine_core_tb;
    import fefe_pkg::*;

    localparam int SHOWN_ROWS   = SHOWN_ROWS_DEF;
    localparam int RANDOM_TICKS = 130;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 3 * SHOWN_ROWS + 20;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [NOISE_W-1:0]    s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int err_cnt;
    int rows_due;
    int idle_cycles = 0;
    int ready_hold  = 0;
    bit sender_fast = 1'b0;

    fire_effect_frame_engine_core #(
        .SHOWN_ROWS(SHOWN_ROWS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    fire_rows_checker #(
        .SHOWN_ROWS(SHOWN_ROWS)
    ) rows_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .o_err_cnt    (err_cnt),
        .o_rows_due   (rows_due)
    );

    always #4 i_clk = ~i_clk;

    // mostly short, now and then long
    function automatic int pick_idle(input int short_max, input int long_max);
        if ($urandom_range(9) == 0) begin
            return $urandom_range(long_max, long_max / 3);
        end
        return $urandom_range(short_max);
    endfunction

    function automatic logic [NOISE_W-1:0] noise_fill(input int lo, input int hi);
        logic [NOISE_W-1:0] noise;
        for (int k = 0; k < NOISE_CNT; k++) begin
            noise[CELL_W*k +: CELL_W] = CELL_W'($urandom_range(hi, lo));
        end
        return noise;
    endfunction

    // receiver: ready runs and stalls of random length, long runs give
    // stretches with no stalls at all
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_axis_tready <= !m_axis_tready;
            ready_hold    <= m_axis_tready ? pick_idle(2, 40) : pick_idle(5, 200);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("fire_effect_frame_engine_core_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called right after a rising edge; returns after the transfer and its gap
    task automatic send_tick(input logic [NOISE_W-1:0] noise);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= noise;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        gap = sender_fast ? 0 : pick_idle(3, 60);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= NOISE_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int sent;
        int burst;
        int mode;
        sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: cold frame, full heat, one hot source column at a time,
        // the palette steps, toggling bits, then cold ticks to cool down
        send_tick('0);
        repeat (3) send_tick('1);
        for (int k = 0; k < NOISE_CNT; k++) begin
            send_tick(NOISE_W'(4'hF) << (CELL_W * k));
        end
        for (int h = 2; h <= 6; h++) begin
            send_tick(noise_fill(h, h));
        end
        send_tick({NOISE_CNT{4'h5}});
        send_tick({NOISE_CNT{4'hA}});
        repeat (3) send_tick('0);

        // random bursts: flat noise, hot fire, embers, or dying out
        while (sent < RANDOM_TICKS) begin
            burst       = $urandom_range(12, 3);
            mode        = $urandom_range(9);
            sender_fast = ($urandom_range(3) == 0);
            repeat (burst) begin
                if (mode < 4) begin
                    send_tick(NOISE_W'($urandom));
                end else if (mode < 7) begin
                    send_tick(noise_fill(9, 15));
                end else if (mode < 9) begin
                    send_tick(noise_fill(2, 6));
                end else begin
                    send_tick('0);
                end
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // the checker's row count is registered, so it lags the last transfer
        @(posedge i_clk);
        while (rows_due != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && rows_due == 0) begin
            $display("fire_effect_frame_engine_core_tb: clean");
        end else begin
            $display("fire_effect_frame_engine_core_tb: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/fefe_pkg.sv
sv/fefe_heat_mem.sv
sv/fefe_burn.sv
sv/fire_effect_frame_engine_core.sv
tb/fire_rows_checker.sv
tb/fire_effect_frame_engine_core_tb.sv
